// ===== src/wpss_pkg.sv =====
// Package for the weighted power-spectrum sum block.
// Widths, register indexes, defaults and the control struct shared by all
// files. No dependencies.
package wpss_pkg;

    localparam int NUM_LANES_DEF  = 4;
    localparam int MAX_DEGREE_DEF = 6;
    localparam int LANE_SLOTS     = 4;

    localparam int LANE_W    = 18;
    localparam int SUM_W     = 20;
    localparam int SQ_W      = 39;
    localparam int MAG_W     = 40;
    localparam int HALF_W    = 20;
    localparam int WEIGHT_W  = 18;
    localparam int PROD_W    = HALF_W + WEIGHT_W;
    localparam int FRAC_DROP = 16;
    localparam int ADD_W     = 42;
    localparam int TOTAL_W   = 54;
    localparam int SPECIES_W = 3;
    localparam int DEG_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [TOTAL_W-1:0]   TOTAL_MAX       = '1;
    localparam logic [SPECIES_W-1:0] SPECIES_RST     = 3'd4;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RST      = 18'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPECIES = 3'd0,
        CFG_WEIGHT0 = 3'd1
    } t_cfg_idx;

    // Control that travels beside the datapath through every stage.
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [WEIGHT_W-1:0] weight;
    } t_ctl;

endpackage

// ===== src/wpss_in_if.sv =====
// Input channel of the weighted power-spectrum sum: valid/ready plus one
// spectrum position. Depends on wpss_pkg.
interface wpss_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [wpss_pkg::LANE_W-1:0] lane0_re;
    logic signed [wpss_pkg::LANE_W-1:0] lane0_im;
    logic signed [wpss_pkg::LANE_W-1:0] lane1_re;
    logic signed [wpss_pkg::LANE_W-1:0] lane1_im;
    logic signed [wpss_pkg::LANE_W-1:0] lane2_re;
    logic signed [wpss_pkg::LANE_W-1:0] lane2_im;
    logic signed [wpss_pkg::LANE_W-1:0] lane3_re;
    logic signed [wpss_pkg::LANE_W-1:0] lane3_im;
    logic        [wpss_pkg::DEG_W-1:0]  degree;
    logic                               last_position;

    modport source (
        output valid, lane0_re, lane0_im, lane1_re, lane1_im,
               lane2_re, lane2_im, lane3_re, lane3_im, degree, last_position,
        input  ready
    );
    modport sink (
        input  valid, lane0_re, lane0_im, lane1_re, lane1_im,
               lane2_re, lane2_im, lane3_re, lane3_im, degree, last_position,
        output ready
    );
endinterface

// ===== src/wpss_out_if.sv =====
// Result channel of the weighted power-spectrum sum: valid/ready plus the
// saturated total and its overflow flag. Depends on wpss_pkg.
interface wpss_out_if;
    logic                                valid;
    logic                                ready;
    logic [wpss_pkg::TOTAL_W-1:0]        kernel_value;
    logic                                overflow;

    modport source (output valid, kernel_value, overflow, input ready);
    modport sink   (input  valid, kernel_value, overflow, output ready);
endinterface

// ===== src/wpss_lane.sv =====
// One species lane: zeroes its complex value when the lane is disabled and
// registers it. Depends on wpss_pkg.
module wpss_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [wpss_pkg::SPECIES_W-1:0]     i_species_used,
    input  logic signed [wpss_pkg::LANE_W-1:0] i_re,
    input  logic signed [wpss_pkg::LANE_W-1:0] i_im,
    output logic signed [wpss_pkg::LANE_W-1:0] o_re,
    output logic signed [wpss_pkg::LANE_W-1:0] o_im
);
    logic                               lane_on;
    logic signed [wpss_pkg::LANE_W-1:0] r_re, r_im;

    assign lane_on = i_species_used > wpss_pkg::SPECIES_W'(LANE_IDX);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_re <= lane_on ? i_re : '0;
            r_im <= lane_on ? i_im : '0;
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;
endmodule

// ===== src/wpss_merge.sv =====
// Merging stage: sums the lanes, squares the real and imaginary sums and
// adds the squares into |S|^2. Three register stages. Depends on wpss_pkg.
module wpss_merge #(
    parameter int NUM_LANES = wpss_pkg::NUM_LANES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  wpss_pkg::t_ctl                     i_ctl,
    input  logic signed [wpss_pkg::LANE_W-1:0] i_re [NUM_LANES],
    input  logic signed [wpss_pkg::LANE_W-1:0] i_im [NUM_LANES],
    output wpss_pkg::t_ctl                     o_ctl,
    output logic [wpss_pkg::MAG_W-1:0]         o_mag
);
    localparam int SUM_W = wpss_pkg::SUM_W;

    logic signed [SUM_W-1:0]     sum_re, sum_im;
    logic signed [2*SUM_W-1:0]   sq_re, sq_im;
    logic signed [SUM_W-1:0]     r_sum_re, r_sum_im;
    logic [wpss_pkg::SQ_W-1:0]   r_sq_re, r_sq_im;
    logic [wpss_pkg::MAG_W-1:0]  r_mag;
    wpss_pkg::t_ctl              r_ctl2, r_ctl3, r_ctl4;

    always_comb begin
        sum_re = '0;
        sum_im = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            sum_re = sum_re + SUM_W'(i_re[k]);
            sum_im = sum_im + SUM_W'(i_im[k]);
        end
    end

    assign sq_re = r_sum_re * r_sum_re;
    assign sq_im = r_sum_im * r_sum_im;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_re <= sum_re;
            r_sum_im <= sum_im;
            r_sq_re  <= sq_re[wpss_pkg::SQ_W-1:0];
            r_sq_im  <= sq_im[wpss_pkg::SQ_W-1:0];
            r_mag    <= wpss_pkg::MAG_W'(r_sq_re) + wpss_pkg::MAG_W'(r_sq_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (i_en) begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    assign o_ctl = r_ctl4;
    assign o_mag = r_mag;
endmodule

// ===== src/wpss_accum.sv =====
// Weighting and accumulation: |S|^2 times the weight as two half products,
// truncation of the 16 fraction bits of the UQ2.16 weight, saturating running total and result register.
// Depends on wpss_pkg.
module wpss_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  wpss_pkg::t_ctl                 i_ctl,
    input  logic [wpss_pkg::MAG_W-1:0]     i_mag,
    input  logic                           i_out_ready,
    output logic                           o_stall,
    output logic                           o_out_valid,
    output logic [wpss_pkg::TOTAL_W-1:0]   o_kernel_value,
    output logic                           o_overflow
);
    localparam int HALF_W  = wpss_pkg::HALF_W;
    localparam int PROD_W  = wpss_pkg::PROD_W;
    localparam int ADD_W   = wpss_pkg::ADD_W;
    localparam int TOTAL_W = wpss_pkg::TOTAL_W;

    logic [PROD_W-1:0]   r_p_lo, r_p_hi;
    logic [ADD_W-1:0]    r_add;
    wpss_pkg::t_ctl      r_ctl5, r_ctl6;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_sat, n_sat;
    logic [TOTAL_W:0]    grown;
    logic                emit;
    logic                r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0]  r_out_kv;
    logic                r_out_ovf;

    // Stage 5: product split on the upper and lower halves of |S|^2.
    // Stage 6: (hi << 20 + lo) >> 16 == hi << 4 + (lo >> 16).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo <= PROD_W'(i_mag[HALF_W-1:0]) * PROD_W'(i_ctl.weight);
            r_p_hi <= PROD_W'(i_mag[2*HALF_W-1:HALF_W]) * PROD_W'(i_ctl.weight);
            r_add  <= (ADD_W'(r_p_hi) << (HALF_W - wpss_pkg::FRAC_DROP))
                    + ADD_W'(r_p_lo >> wpss_pkg::FRAC_DROP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl5 <= '0;
            r_ctl6 <= '0;
        end else if (i_en) begin
            r_ctl5 <= i_ctl;
            r_ctl6 <= r_ctl5;
        end
    end

    assign grown   = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(r_add);
    assign emit    = i_en && r_ctl6.valid && r_ctl6.last;
    assign o_stall = r_ctl6.valid && r_ctl6.last && r_out_valid && !i_out_ready;

    always_comb begin
        n_total     = r_total;
        n_sat       = r_sat;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_en && r_ctl6.valid) begin
            if (grown > (TOTAL_W+1)'(wpss_pkg::TOTAL_MAX)) begin
                n_total = wpss_pkg::TOTAL_MAX;
                n_sat   = 1'b1;
            end else begin
                n_total = grown[TOTAL_W-1:0];
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= emit ? '0 : n_total;
            r_sat       <= emit ? 1'b0 : n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kv  <= n_total;
            r_out_ovf <= n_sat;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kernel_value = r_out_kv;
    assign o_overflow     = r_out_ovf;

    a_sat_pins_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> r_total == wpss_pkg::TOTAL_MAX)
        else $error("saturated flag set but total not at max");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_total == '0) && !r_sat)
        else $error("total not cleared after emit");

    a_ovf_result_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ovf |-> r_out_kv == wpss_pkg::TOTAL_MAX)
        else $error("overflow result without saturated value");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid && r_ctl6.last)
        else $error("stall without a pending result");
endmodule

// ===== src/weighted_power_spectrum_sum.sv =====
// Top level of the weighted power-spectrum sum: config registers, species
// lanes, merging stage and accumulator.
// Depends on wpss_pkg, wpss_in_if, wpss_out_if, wpss_lane, wpss_merge, wpss_accum.
//
//   port      dir  kind        contents
//   i_item    in   valid/ready lane0..3 re/im, degree, last_position
//   o_result  out  valid/ready kernel_value, overflow
//   i_cfg_*   in   write only  species_used (index 0), weight_deg0..6 (1..7)
//
// One item per cycle while not stalled; the result register loads as the last item is added into the total.
// The pipeline is a fixed chain: lane register, lane sum, squares, |S|^2,
// half products, truncated product, saturating accumulator.
// Reset (synchronous, active low) clears valids, totals and config to defaults.
// Input stalls only while a last item waits behind an untaken result.
module weighted_power_spectrum_sum #(
    parameter int NUM_LANES  = wpss_pkg::NUM_LANES_DEF,
    parameter int MAX_DEGREE = wpss_pkg::MAX_DEGREE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wpss_in_if.sink                           i_item,
    wpss_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [wpss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wpss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int LANE_W = wpss_pkg::LANE_W;

    logic [wpss_pkg::SPECIES_W-1:0] r_species;
    logic [wpss_pkg::WEIGHT_W-1:0]  r_weight [MAX_DEGREE+1];
    logic [wpss_pkg::WEIGHT_W-1:0]  sel_weight;
    logic                           en, stall;
    wpss_pkg::t_ctl                 r_ctl1, ctl4;
    logic [wpss_pkg::MAG_W-1:0]     mag;

    logic signed [LANE_W-1:0] in_re [wpss_pkg::LANE_SLOTS];
    logic signed [LANE_W-1:0] in_im [wpss_pkg::LANE_SLOTS];
    logic signed [LANE_W-1:0] lane_re [NUM_LANES];
    logic signed [LANE_W-1:0] lane_im [NUM_LANES];

    assign en = !stall;
    assign i_item.ready = en;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_species <= wpss_pkg::SPECIES_RST;
        end else if (i_cfg_we && i_cfg_idx == wpss_pkg::CFG_SPECIES) begin
            r_species <= i_cfg_data[wpss_pkg::SPECIES_W-1:0];
        end
    end

    for (genvar d = 0; d <= MAX_DEGREE; d++) begin : g_weight
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_weight[d] <= wpss_pkg::WEIGHT_RST;
            end else if (i_cfg_we && i_cfg_idx ==
                         wpss_pkg::CFG_IDX_W'(wpss_pkg::CFG_WEIGHT0 + d)) begin
                r_weight[d] <= i_cfg_data[wpss_pkg::WEIGHT_W-1:0];
            end
        end
    end

    // Degrees above MAX_DEGREE get weight zero.
    always_comb begin
        sel_weight = '0;
        for (int d = 0; d <= MAX_DEGREE; d++) begin
            if (i_item.degree == wpss_pkg::DEG_W'(d)) begin
                sel_weight = r_weight[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (en) begin
            r_ctl1.valid  <= i_item.valid;
            r_ctl1.last   <= i_item.last_position;
            r_ctl1.weight <= sel_weight;
        end
    end

    assign in_re[0] = i_item.lane0_re;
    assign in_im[0] = i_item.lane0_im;
    assign in_re[1] = i_item.lane1_re;
    assign in_im[1] = i_item.lane1_im;
    assign in_re[2] = i_item.lane2_re;
    assign in_im[2] = i_item.lane2_im;
    assign in_re[3] = i_item.lane3_re;
    assign in_im[3] = i_item.lane3_im;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        wpss_lane #(.LANE_IDX(g)) u_lane (
            .i_clk          (i_clk),
            .i_en           (en),
            .i_species_used (r_species),
            .i_re           (in_re[g]),
            .i_im           (in_im[g]),
            .o_re           (lane_re[g]),
            .o_im           (lane_im[g])
        );
    end

    wpss_merge #(.NUM_LANES(NUM_LANES)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_ctl1),
        .i_re    (lane_re),
        .i_im    (lane_im),
        .o_ctl   (ctl4),
        .o_mag   (mag)
    );

    wpss_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_ctl          (ctl4),
        .i_mag          (mag),
        .i_out_ready    (o_result.ready),
        .o_stall        (stall),
        .o_out_valid    (o_result.valid),
        .o_kernel_value (o_result.kernel_value),
        .o_overflow     (o_result.overflow)
    );
endmodule
